@@ rtl/core/prfirst_pkg.sv @@
`default_nettype none

package prfirst_pkg;

  localparam int unsigned HandleW = 16;
  localparam int unsigned CapW    = 32;

  localparam logic [CapW-1:0] MinCapacity = 32'd64;
  localparam logic [CapW-1:0] MaxCapacity = 32'h8000_0000;

  typedef enum logic {
    REQ_RECLAIM = 1'b0,
    REQ_GET     = 1'b1
  } req_type_e;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_STORED   = 3'd2,
    ST_REPLACED = 3'd3,
    ST_DROPPED  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_SHIFT,
    FSM_DONE
  } fsm_e;

  typedef struct packed {
    req_type_e         req_type;
    logic [HandleW-1:0] pool_handle;
    logic [CapW-1:0]    capacity_value;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [HandleW-1:0] out_handle;
    logic [CapW-1:0]    out_capacity;
  } rsp_t;

  // next power of two at or above the request, floor 64, saturating at 2^31
  function automatic logic [CapW-1:0] round_capacity(logic [CapW-1:0] cap);
    logic [CapW-1:0] v;
    logic [CapW-1:0] x;
    v = (cap > MaxCapacity) ? MaxCapacity : cap;
    x = v - 32'd1;
    x = x | (x >> 1);
    x = x | (x >> 2);
    x = x | (x >> 4);
    x = x | (x >> 8);
    x = x | (x >> 16);
    return (v <= MinCapacity) ? MinCapacity : (x + 32'd1);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/pool_recycler_first_fit.sv @@
// Recycled pool list, first-fit reuse.
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one request word:
// a reclaim (store a pool handle and its capacity) or a get (ask for a pool
// of at least a minimum capacity). Output channel (out_valid_o / out_stall_i /
// out_data_o) returns exactly one result word per request.
// The list lives in one synchronous RAM of LIST_DEPTH entries, read one entry
// per cycle. A reclaim into a list that is not full is written at acceptance
// and its result goes through the done state to the output register. A get or
// a reclaim into a full list walks the list from the front, one entry per
// cycle; a get hit then closes up the list, one entry per cycle.
// One request is worked on at a time; a new one is accepted while the
// previous result still waits in the output register.
// Reset empties the list (entry count to zero) and drops any pending result;
// there is no clearing pass. A stalled receiver holds the result word, and
// the block waits with the next result until the register is free.
`default_nettype none

module pool_recycler_first_fit #(
  parameter int unsigned LIST_DEPTH  = 32,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire prfirst_pkg::req_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output prfirst_pkg::rsp_t       out_data_o
);

  localparam int unsigned HB = (HANDLE_BITS < prfirst_pkg::HandleW) ?
                               HANDLE_BITS : prfirst_pkg::HandleW;
  localparam int unsigned EW = HB + prfirst_pkg::CapW;
  localparam int unsigned IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

  prfirst_pkg::fsm_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] ra_q, ra_d;
  logic          ck_vld_q, ck_vld_d;
  logic [IW-1:0] ck_idx_q, ck_idx_d;
  logic [IW-1:0] wp_q, wp_d;

  prfirst_pkg::req_type_e type_q, type_d;
  logic [HB-1:0]                  handle_q, handle_d;
  logic [prfirst_pkg::CapW-1:0]   key_q, key_d;
  prfirst_pkg::rsp_t              res_q, res_d;
  logic                           out_valid_q, out_valid_d;
  prfirst_pkg::rsp_t              out_q, out_d;

  // list RAM
  logic [EW-1:0] mem [LIST_DEPTH];
  logic [EW-1:0] rdata_q;
  logic          re, we;
  logic [IW-1:0] rd_addr, wa;
  logic [EW-1:0] wd;

  logic [prfirst_pkg::CapW-1:0] rd_cap;
  logic [HB-1:0]                rd_handle;
  logic                         hit;
  logic                         accept;

  assign rd_cap    = rdata_q[prfirst_pkg::CapW-1:0];
  assign rd_handle = rdata_q[EW-1:prfirst_pkg::CapW];
  assign hit = ck_vld_q && ((type_q == prfirst_pkg::REQ_GET) ? (rd_cap >= key_q)
                                                            : (rd_cap < key_q));

  assign in_stall_o  = (state_q != prfirst_pkg::FSM_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= prfirst_pkg::FSM_IDLE;
      count_q     <= '0;
      ra_q        <= '0;
      ck_vld_q    <= 1'b0;
      ck_idx_q    <= '0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ra_q        <= ra_d;
      ck_vld_q    <= ck_vld_d;
      ck_idx_q    <= ck_idx_d;
      wp_q        <= wp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q   <= type_d;
    handle_q <= handle_d;
    key_q    <= key_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ra_d        = ra_q;
    ck_vld_d    = 1'b0;
    ck_idx_d    = ck_idx_q;
    wp_d        = wp_q;
    type_d      = type_q;
    handle_d    = handle_q;
    key_d       = key_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    re          = 1'b0;
    rd_addr     = ra_q[IW-1:0];
    we          = 1'b0;
    wa          = wp_q;
    wd          = {handle_q, key_q};

    unique case (state_q)
      prfirst_pkg::FSM_IDLE: begin
        if (accept) begin
          type_d   = in_data_i.req_type;
          handle_d = in_data_i.pool_handle[HB-1:0];
          key_d    = (in_data_i.req_type == prfirst_pkg::REQ_GET) ?
                     prfirst_pkg::round_capacity(in_data_i.capacity_value) :
                     in_data_i.capacity_value;
          ra_d     = '0;
          if (in_data_i.req_type == prfirst_pkg::REQ_RECLAIM &&
              count_q < CW'(LIST_DEPTH)) begin
            // room left: append at the tail
            we                 = 1'b1;
            wa                 = count_q[IW-1:0];
            wd                 = {in_data_i.pool_handle[HB-1:0],
                                  in_data_i.capacity_value};
            count_d            = count_q + CW'(1);
            res_d.status       = prfirst_pkg::ST_STORED;
            res_d.out_handle   = '0;
            res_d.out_capacity = '0;
            state_d            = prfirst_pkg::FSM_DONE;
          end else begin
            state_d = prfirst_pkg::FSM_SCAN;
          end
        end
      end

      prfirst_pkg::FSM_SCAN: begin
        if (hit) begin
          res_d.out_handle   = prfirst_pkg::HandleW'(rd_handle);
          res_d.out_capacity = rd_cap;
          if (type_q == prfirst_pkg::REQ_GET) begin
            res_d.status = prfirst_pkg::ST_HIT;
            count_d      = count_q - CW'(1);
            wp_d         = ck_idx_q;
            ra_d         = CW'(ck_idx_q) + CW'(1);
            state_d      = prfirst_pkg::FSM_SHIFT;
          end else begin
            res_d.status = prfirst_pkg::ST_REPLACED;
            we           = 1'b1;
            wa           = ck_idx_q;
            state_d      = prfirst_pkg::FSM_DONE;
          end
        end else if (ra_q < count_q) begin
          re       = 1'b1;
          ra_d     = ra_q + CW'(1);
          ck_vld_d = 1'b1;
          ck_idx_d = ra_q[IW-1:0];
        end else if (!ck_vld_q) begin
          // walked the whole list without a match
          if (type_q == prfirst_pkg::REQ_GET) begin
            res_d.status       = prfirst_pkg::ST_MISS;
            res_d.out_handle   = '0;
            res_d.out_capacity = key_q;
          end else begin
            res_d.status       = prfirst_pkg::ST_DROPPED;
            res_d.out_handle   = prfirst_pkg::HandleW'(handle_q);
            res_d.out_capacity = key_q;
          end
          state_d = prfirst_pkg::FSM_DONE;
        end
      end

      prfirst_pkg::FSM_SHIFT: begin
        // close-up: read entry p+1 while writing the entry read before it (entry p) into slot p-1
        if (ck_vld_q) begin
          we   = 1'b1;
          wa   = wp_q;
          wd   = rdata_q;
          wp_d = wp_q + IW'(1);
        end
        if (ra_q <= count_q) begin
          re       = 1'b1;
          ra_d     = ra_q + CW'(1);
          ck_vld_d = 1'b1;
        end else if (!ck_vld_q) begin
          state_d = prfirst_pkg::FSM_DONE;
        end
      end

      prfirst_pkg::FSM_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = prfirst_pkg::FSM_IDLE;
        end
      end

      default: begin
        state_d = prfirst_pkg::FSM_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(LIST_DEPTH))
    else $error("entry count above list depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |->
      (count_q == $past(count_q) + CW'(1)) || (count_q == $past(count_q) - CW'(1)))
    else $error("entry count moved by more than one");

  a_shift_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == prfirst_pkg::FSM_SHIFT && we) |-> (CW'(wa) < count_q))
    else $error("close-up write beyond list tail");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == prfirst_pkg::FSM_DONE)
    else $error("result word loaded outside done state");

endmodule

`default_nettype wire

@@ tb/sv/pool_list_checker.sv @@
`timescale 1ns / 100ps

module pool_list_checker #(
  parameter int unsigned LIST_DEPTH = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_stall_i,
  input  wire prfirst_pkg::req_t  in_data_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_stall_i,
  input  wire prfirst_pkg::rsp_t  out_data_i,
  output int                      failures_o,
  output int                      pending_o
);

  // shadow copy of the recycled pool list
  logic [prfirst_pkg::HandleW-1:0] pool_handle_q [LIST_DEPTH];
  logic [prfirst_pkg::CapW-1:0]    pool_cap_q    [LIST_DEPTH];
  int                              pool_len;

  prfirst_pkg::rsp_t awaited_rsp_q [$];
  prfirst_pkg::rsp_t want;

  function automatic logic [prfirst_pkg::CapW-1:0] pow2_ceiling(
      logic [prfirst_pkg::CapW-1:0] minimum);
    logic [prfirst_pkg::CapW-1:0] lim;
    logic [prfirst_pkg::CapW-1:0] r;
    lim = (minimum > prfirst_pkg::MaxCapacity) ? prfirst_pkg::MaxCapacity : minimum;
    r = prfirst_pkg::MinCapacity;
    while (r < lim) r = r << 1;
    return r;
  endfunction

  // apply one request word to the shadow list and return its response word
  function automatic prfirst_pkg::rsp_t serve_request(prfirst_pkg::req_t r);
    prfirst_pkg::rsp_t            res;
    logic [prfirst_pkg::CapW-1:0] need;
    res.status       = prfirst_pkg::ST_STORED;
    res.out_handle   = '0;
    res.out_capacity = '0;
    if (r.req_type == prfirst_pkg::REQ_GET) begin
      need = pow2_ceiling(r.capacity_value);
      res.status       = prfirst_pkg::ST_MISS;
      res.out_capacity = need;
      for (int i = 0; i < pool_len; i++) begin
        if (pool_cap_q[i] >= need) begin
          res.status       = prfirst_pkg::ST_HIT;
          res.out_handle   = pool_handle_q[i];
          res.out_capacity = pool_cap_q[i];
          for (int j = i; j + 1 < pool_len; j++) begin
            pool_handle_q[j] = pool_handle_q[j+1];
            pool_cap_q[j]    = pool_cap_q[j+1];
          end
          pool_len--;
          break;
        end
      end
    end else if (pool_len < LIST_DEPTH) begin
      pool_handle_q[pool_len] = r.pool_handle;
      pool_cap_q[pool_len]    = r.capacity_value;
      pool_len++;
    end else begin
      // full: evict the first strictly smaller entry, else drop the incoming word
      res.status       = prfirst_pkg::ST_DROPPED;
      res.out_handle   = r.pool_handle;
      res.out_capacity = r.capacity_value;
      for (int i = 0; i < pool_len; i++) begin
        if (pool_cap_q[i] < r.capacity_value) begin
          res.status       = prfirst_pkg::ST_REPLACED;
          res.out_handle   = pool_handle_q[i];
          res.out_capacity = pool_cap_q[i];
          pool_handle_q[i] = r.pool_handle;
          pool_cap_q[i]    = r.capacity_value;
          break;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_len = 0;
      awaited_rsp_q.delete();
      failures_o = 0;
      pending_o  = 0;
    end else begin
      // output first: a response never belongs to a word accepted on the same edge
      if (out_valid_i && !out_stall_i) begin
        if (awaited_rsp_q.size() == 0) begin
          $error("unexpected response word: status %0d handle 0x%04h capacity 0x%08h",
                 out_data_i.status, out_data_i.out_handle, out_data_i.out_capacity);
          failures_o++;
        end else begin
          want = awaited_rsp_q.pop_front();
          if (out_data_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data_i.status);
            failures_o++;
          end
          if (out_data_i.out_handle !== want.out_handle) begin
            $error("out_handle: expected 0x%04h, got 0x%04h",
                   want.out_handle, out_data_i.out_handle);
            failures_o++;
          end
          if (out_data_i.out_capacity !== want.out_capacity) begin
            $error("out_capacity: expected 0x%08h, got 0x%08h",
                   want.out_capacity, out_data_i.out_capacity);
            failures_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_rsp_q.insert(awaited_rsp_q.size(), serve_request(in_data_i));
      end
      pending_o = awaited_rsp_q.size();
    end
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;

  localparam int unsigned ListDepth   = 32;
  localparam int unsigned RandomItems = 560;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 2 * ListDepth + 8;

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  prfirst_pkg::req_t in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  prfirst_pkg::rsp_t out_data;

  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned cycles        = 0;
  int unsigned sent          = 0;
  int          failures;
  int          pending;

  pool_recycler_first_fit #(
    .LIST_DEPTH (ListDepth),
    .HANDLE_BITS(16)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  pool_list_checker #(
    .LIST_DEPTH(ListDepth)
  ) u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_data_i (out_data),
    .failures_o (failures),
    .pending_o  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < sink_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // sizes that repeat often, so ties and hits are common
  function automatic logic [prfirst_pkg::CapW-1:0] common_capacity();
    case ($urandom_range(0, 3))
      0:       return 32'd64;
      1:       return 32'd256;
      2:       return 32'd4096;
      default: return 32'h0010_0000;
    endcase
  endfunction

  function automatic logic [prfirst_pkg::CapW-1:0] any_capacity();
    logic [prfirst_pkg::CapW-1:0] p;
    p = 32'd1 << $urandom_range(0, 31);
    case ($urandom_range(0, 7))
      0:       return p;
      1:       return p + 32'd1;
      2:       return p - 32'd1;
      3:       return $urandom_range(0, 130);
      4:       return $urandom;
      5:       return prfirst_pkg::MaxCapacity + $urandom_range(0, 2);
      6:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return common_capacity();
    endcase
  endfunction

  task automatic push_request(input prfirst_pkg::req_type_e kind,
                              input logic [prfirst_pkg::HandleW-1:0] hnd,
                              input logic [prfirst_pkg::CapW-1:0] cap);
    prfirst_pkg::req_t w;
    w.req_type       = kind;
    w.pool_handle    = hnd;
    w.capacity_value = cap;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  function automatic logic [prfirst_pkg::HandleW-1:0] any_handle();
    return prfirst_pkg::HandleW'($urandom_range(0, 16'hFFFF));
  endfunction

  initial begin
    logic [prfirst_pkg::CapW-1:0] c;
    int unsigned                  target;
    int unsigned                  kind;
    int unsigned                  len;

    src_idle_pct  = 22;
    sink_idle_pct = 46;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // rounding on an empty list: floor, exact power, one above, saturation
    push_request(prfirst_pkg::REQ_GET, 16'h0000, 32'd0);
    push_request(prfirst_pkg::REQ_GET, 16'hFFFF, 32'd64);
    push_request(prfirst_pkg::REQ_GET, 16'h0000, 32'd65);
    push_request(prfirst_pkg::REQ_GET, 16'h0000, 32'h8000_0000);
    push_request(prfirst_pkg::REQ_GET, 16'h0000, 32'h8000_0001);
    push_request(prfirst_pkg::REQ_GET, 16'h0000, 32'hFFFF_FFFF);
    // reclaims stored as-is, then first-fit reuse and close-up
    push_request(prfirst_pkg::REQ_RECLAIM, 16'hFFFF, 32'hFFFF_FFFF);
    push_request(prfirst_pkg::REQ_RECLAIM, 16'h0000, 32'd0);
    push_request(prfirst_pkg::REQ_RECLAIM, 16'h1234, 32'd64);
    push_request(prfirst_pkg::REQ_RECLAIM, 16'h5678, 32'd100);
    push_request(prfirst_pkg::REQ_GET, 16'h0000, 32'd100);
    push_request(prfirst_pkg::REQ_GET, 16'h0000, 32'd1);
    push_request(prfirst_pkg::REQ_GET, 16'h0000, 32'hFFFF_FFFF);
    push_request(prfirst_pkg::REQ_GET, 16'h0000, 32'd128);
    push_request(prfirst_pkg::REQ_GET, 16'h0000, 32'd64);
    push_request(prfirst_pkg::REQ_RECLAIM, 16'hA5A5, 32'h8000_0000);
    push_request(prfirst_pkg::REQ_GET, 16'h0000, 32'hFFFF_FFFF);

    // fill with one size: evict the tiny leftover, then ties and a smaller one drop, a larger one evicts
    c = common_capacity();
    repeat (33) push_request(prfirst_pkg::REQ_RECLAIM, any_handle(), c);
    push_request(prfirst_pkg::REQ_RECLAIM, any_handle(), c);
    push_request(prfirst_pkg::REQ_RECLAIM, any_handle(), c - 32'd1);
    push_request(prfirst_pkg::REQ_RECLAIM, any_handle(), c + 32'd1);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin src_idle_pct = 22; sink_idle_pct = 46; end
        1: begin src_idle_pct = 46; sink_idle_pct = 22; end
        default: begin src_idle_pct = 0; sink_idle_pct = 0; end
      endcase
      target = sent + RandomItems / 3;
      while (sent < target) begin
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
          // fill run: mostly reclaims, enough to reach a full list
          len = $urandom_range(20, 45);
          repeat (len) begin
            if ($urandom_range(99) < 10) begin
              push_request(prfirst_pkg::REQ_GET, any_handle(), $urandom_range(0, 300));
            end else if ($urandom_range(99) < 70) begin
              push_request(prfirst_pkg::REQ_RECLAIM, any_handle(), common_capacity());
            end else begin
              push_request(prfirst_pkg::REQ_RECLAIM, any_handle(), any_capacity());
            end
          end
        end else if (kind < 7) begin
          // drain run: mostly gets with modest minima, so most hit
          len = $urandom_range(5, 40);
          repeat (len) begin
            if ($urandom_range(99) < 10) begin
              push_request(prfirst_pkg::REQ_RECLAIM, any_handle(), any_capacity());
            end else if ($urandom_range(99) < 70) begin
              push_request(prfirst_pkg::REQ_GET, any_handle(), $urandom_range(0, 300));
            end else begin
              push_request(prfirst_pkg::REQ_GET, any_handle(), any_capacity());
            end
          end
        end else begin
          len = $urandom_range(5, 30);
          repeat (len) begin
            push_request(prfirst_pkg::req_type_e'($urandom_range(0, 1)), any_handle(),
                         any_capacity());
          end
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (failures == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/prfirst_pkg.sv
rtl/core/pool_recycler_first_fit.sv
tb/sv/pool_list_checker.sv
tb/sv/tb.sv
